// File: hw/rtl/iqmh_pkg.sv
`timescale 1ns / 1ps
package iqmh_pkg;
   localparam int DefCapacity = 256;
   localparam int DefHandles  = 1024;
   localparam int DefArity    = 4;
   localparam int CmdW = 2;
   localparam int HandleW = 10;
   localparam int KeyW = 32;
   localparam int StatusW = 3;
   localparam int CountW = 9;
   localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
   localparam logic [CmdW-1:0] CMD_DELETE = 2'd1;
   localparam logic [CmdW-1:0] CMD_PEEK   = 2'd2;
   localparam logic [CmdW-1:0] CMD_POP    = 2'd3;
   localparam logic [StatusW-1:0] ST_OK      = 3'd0;
   localparam logic [StatusW-1:0] ST_EMPTY   = 3'd1;
   localparam logic [StatusW-1:0] ST_FULL    = 3'd2;
   localparam logic [StatusW-1:0] ST_ABSENT  = 3'd3;
   localparam logic [StatusW-1:0] ST_PRESENT = 3'd4;
endpackage

// File: hw/rtl/indexed_quad_max_heap_core.sv
`timescale 1ns / 1ps
// Channel  Direction  tdata (low bit first)                       tuser
// req      in         command[1:0], handle[11:2], key[43:12]      none
// rsp      out        status[2:0], top_handle[12:3], top_key[44:13],
//                     entry_count[53:45]                           none
// One command at a time. Peek passes through the map lookup state and then the result
// register. Insert spends one lookup step, delete and pop also the look, last-slot read
// and last-slot write states; sift-up then reads and compares the parent at each level and
// sift-down reads each child and then decides per level, paced by the single port of the
// slot memory. The final write, where one is needed, and the result register follow. After
// reset the position map is swept, one handle a cycle, with req_tready low.
// A result waits in an output register; the next command is taken once it is accepted.
module indexed_quad_max_heap_core #(
   parameter int HEAP_CAPACITY = iqmh_pkg::DefCapacity,
   parameter int HANDLE_COUNT  = iqmh_pkg::DefHandles,
   parameter int ARITY         = iqmh_pkg::DefArity
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // command, handle, key, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // status, top_handle, top_key, entry_count, zero fill
);
   import iqmh_pkg::*;
   localparam int SW = $clog2(HEAP_CAPACITY + 1);
   localparam int PW = $clog2(HEAP_CAPACITY);
   localparam int HW = $clog2(HANDLE_COUNT);
   localparam int AW = $clog2(ARITY + 1);

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_MAP = 4'd2, S_LOOK = 4'd3,
      S_RDLAST = 4'd4, S_WLAST = 4'd5, S_UPRD = 4'd6, S_UPCMP = 4'd7, S_DNRD = 4'd8,
      S_DNCMP = 4'd9, S_DNDEC = 4'd10, S_PLACE = 4'd11, S_RSP = 4'd12, S_TOP = 4'd13,
      S_TOPW = 4'd14;

   logic [HandleW+KeyW-1:0] slot_mem [HEAP_CAPACITY];
   logic [PW:0]              map_mem  [HANDLE_COUNT];

   logic [3:0]          state_ff, state_in;
   logic [SW-1:0]       size_ff, size_in;
   logic [HW:0]         clr_ff, clr_in;
   logic [CmdW-1:0]     cmd_ff, cmd_in;
   logic [HandleW-1:0]  h_ff, h_in, mh_ff, mh_in, th_ff, th_in;
   logic [KeyW-1:0]     k_ff, k_in, mk_ff, mk_in, tk_ff, tk_in, bk_ff, bk_in;
   logic [PW-1:0]       x_ff, x_in, bp_ff, bp_in, pos_ff, pos_in;
   logic [AW-1:0]       ci_ff, ci_in;
   logic                bv_ff, bv_in;
   logic [StatusW-1:0]  st_ff, st_in;
   logic                rv_ff, rv_in;

   logic                 s_we, m_we;
   logic [PW-1:0]        s_addr;
   logic [HandleW+KeyW-1:0] s_wd, s_rd_ff;
   logic [HW-1:0]        m_waddr, m_raddr;
   logic [PW:0]          m_wd, m_rd_ff;
   logic [HandleW-1:0]   rd_h;
   logic [KeyW-1:0]      rd_k;
   logic [31:0]          child_first;
   logic [31:0]          child_cur;

   always_ff @(posedge clock) begin
      if (s_we) slot_mem[s_addr] <= s_wd;
      s_rd_ff <= slot_mem[s_addr];
      if (m_we) map_mem[m_waddr] <= m_wd;
      m_rd_ff <= map_mem[m_raddr];
   end

   assign rd_h = s_rd_ff[HandleW-1:0];
   assign rd_k = s_rd_ff[HandleW+KeyW-1:HandleW];
   assign child_first = 32'(ARITY) * 32'(x_ff) + 32'd1;
   assign child_cur = child_first + 32'(ci_ff);

   always_comb begin
      state_in = state_ff; size_in = size_ff; clr_in = clr_ff; cmd_in = cmd_ff;
      h_in = h_ff; k_in = k_ff; mh_in = mh_ff; mk_in = mk_ff; th_in = th_ff;
      tk_in = tk_ff; bk_in = bk_ff; x_in = x_ff; bp_in = bp_ff; pos_in = pos_ff;
      ci_in = ci_ff; bv_in = bv_ff; st_in = st_ff; rv_in = rv_ff;
      s_we = 1'b0; s_addr = x_ff; s_wd = {mk_ff, mh_ff};
      m_we = 1'b0; m_waddr = h_ff[HW-1:0]; m_raddr = h_ff[HW-1:0];
      m_wd = {1'b1, x_ff};
      req_tready = 1'b0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1; m_waddr = clr_ff[HW-1:0]; m_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (HW+1)'(HANDLE_COUNT - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = !rv_ff || rsp_tready;
            cmd_in = req_tdata[1:0]; h_in = req_tdata[11:2]; k_in = req_tdata[43:12];
            m_raddr = req_tdata[HW+1:2];
            s_addr = '0;
            if (req_tvalid && req_tready) state_in = S_MAP;
         end
         S_MAP: begin
            // Slot 0 read data and map read data are both valid here.
            st_in = ST_OK; state_in = S_RSP;
            th_in = '0; tk_in = '0;
            s_addr = PW'(size_ff - 1'b1);
            case (cmd_ff)
               CMD_INSERT: begin
                  if (32'(h_ff) >= 32'(HANDLE_COUNT)) st_in = ST_ABSENT;
                  else if (m_rd_ff[PW]) st_in = ST_PRESENT;
                  else if (32'(size_ff) >= 32'(HEAP_CAPACITY)) st_in = ST_FULL;
                  else begin
                     mh_in = h_ff; mk_in = k_ff; x_in = PW'(size_ff);
                     size_in = size_ff + 1'b1; state_in = S_UPRD;
                  end
               end
               CMD_DELETE: begin
                  if (32'(h_ff) >= 32'(HANDLE_COUNT) || !m_rd_ff[PW] ||
                      32'(m_rd_ff[PW-1:0]) >= 32'(size_ff)) st_in = ST_ABSENT;
                  else begin
                     pos_in = m_rd_ff[PW-1:0]; state_in = S_LOOK;
                  end
               end
               default: begin
                  if (size_ff == '0) st_in = ST_EMPTY;
                  else begin
                     th_in = rd_h; tk_in = rd_k;
                     if (cmd_ff == CMD_POP) begin
                        pos_in = '0; state_in = S_LOOK;
                     end
                  end
               end
            endcase
         end
         S_LOOK: begin
            s_addr = pos_ff; state_in = S_RDLAST;
         end
         S_RDLAST: begin
            // Removed entry data arrives; request the last slot.
            bk_in = rd_k;
            m_we = 1'b1; m_waddr = rd_h[HW-1:0]; m_wd = '0;
            s_addr = PW'(size_ff - 1'b1);
            state_in = S_WLAST;
         end
         S_WLAST: begin
            mh_in = rd_h; mk_in = rd_k; x_in = pos_ff;
            size_in = size_ff - 1'b1;
            if (32'(pos_ff) == 32'(size_ff) - 32'd1) state_in = S_RSP;
            else if ($signed(bk_ff) >= $signed(rd_k)) state_in = S_DNRD;
            else state_in = S_UPRD;
            ci_in = '0; bv_in = 1'b0;
         end
         S_UPRD: begin
            if (x_ff == '0) state_in = S_PLACE;
            else begin
               bp_in = PW'((32'(x_ff) - 32'd1) / 32'(ARITY));
               s_addr = PW'((32'(x_ff) - 32'd1) / 32'(ARITY));
               state_in = S_UPCMP;
            end
         end
         S_UPCMP: begin
            if ($signed(rd_k) < $signed(mk_ff)) begin
               s_we = 1'b1; s_addr = x_ff; s_wd = s_rd_ff;
               m_we = 1'b1; m_waddr = rd_h[HW-1:0]; m_wd = {1'b1, x_ff};
               x_in = bp_ff; state_in = S_UPRD;
            end else state_in = S_PLACE;
         end
         S_DNRD: begin
            if (child_cur >= 32'(size_ff) || ci_ff == AW'(ARITY)) state_in = S_DNDEC;
            else begin
               s_addr = PW'(child_cur); state_in = S_DNCMP;
            end
         end
         S_DNCMP: begin
            if (!bv_ff || $signed(bk_ff) < $signed(rd_k)) begin
               bv_in = 1'b1; bk_in = rd_k; th_in = (cmd_ff == CMD_POP) ? th_ff : th_ff;
               bp_in = PW'(child_cur);
               mh_in = mh_ff;
            end
            ci_in = ci_ff + 1'b1; state_in = S_DNRD;
            if (!bv_ff || $signed(bk_ff) < $signed(rd_k)) h_in = rd_h;
         end
         S_DNDEC: begin
            if (bv_ff && $signed(mk_ff) < $signed(bk_ff)) begin
               s_we = 1'b1; s_addr = x_ff; s_wd = {bk_ff, h_ff};
               m_we = 1'b1; m_waddr = h_ff[HW-1:0]; m_wd = {1'b1, x_ff};
               x_in = bp_ff; ci_in = '0; bv_in = 1'b0; state_in = S_DNRD;
            end else state_in = S_PLACE;
         end
         S_PLACE: begin
            s_we = 1'b1; s_addr = x_ff; s_wd = {mk_ff, mh_ff};
            m_we = 1'b1; m_waddr = mh_ff[HW-1:0]; m_wd = {1'b1, x_ff};
            state_in = S_RSP;
         end
         S_RSP: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         S_TOP, S_TOPW: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; size_ff <= '0; clr_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; size_ff <= size_in; clr_ff <= clr_in; rv_ff <= rv_in;
      end
      cmd_ff <= cmd_in; h_ff <= h_in; k_ff <= k_in; mh_ff <= mh_in; mk_ff <= mk_in;
      th_ff <= th_in; tk_ff <= tk_in; bk_ff <= bk_in; x_ff <= x_in; bp_ff <= bp_in;
      pos_ff <= pos_in; ci_ff <= ci_in; bv_ff <= bv_in; st_ff <= st_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {2'b00, CountW'(size_ff), tk_ff, th_ff, st_ff};
endmodule
